FILE: rtl/dssb_pkg.sv
// Shared types and constants for the dual stack shared buffer.
package dssb_pkg;

	localparam int DATA_W = 32;

	// Action codes
	localparam logic [2:0] ACT_PUSH_LO = 3'd0;
	localparam logic [2:0] ACT_PUSH_HI = 3'd1;
	localparam logic [2:0] ACT_POP_LO  = 3'd2;
	localparam logic [2:0] ACT_POP_HI  = 3'd3;
	localparam logic [2:0] ACT_DUMP_LO = 3'd4;
	localparam logic [2:0] ACT_DUMP_HI = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVER  = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// Input transaction
	typedef struct packed {
		logic [2:0]               action;
		logic signed [DATA_W-1:0] push_value;
	} item_t;

	// Result transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic [1:0]               status;
		logic                     last;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       ld_item;
		logic       wr_en;
		logic       rd_en;
		logic       rd_last;
		logic       cnt_up;
		logic       cnt_down;
		logic       idx_inc;
		logic       emit;
		logic [1:0] emit_st;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [2:0] action;
		logic       full;
		logic       lo_empty;
		logic       hi_empty;
		logic       dump_last;
	} dp_stat_t;

endpackage

FILE: rtl/dual_stack_shared_buffer.sv
// Top level of the dual stack shared buffer: controller plus datapath.
//
// Two stacks share one store of DEPTH 32-bit entries; the first grows up
// from entry 0, the second down from entry DEPTH-1.
// Input channel: a transaction (item.action, item.push_value) is accepted
// on a rising edge with start high and busy low. busy stays high until the
// transaction's results have all been placed in the result register.
// Result channel: valid is high for exactly one cycle per result, with the
// result fields held in a register; the receiver cannot stall the block.
// Steps, from the accepting edge:
//   push, failed pop, empty dump: S_EXEC issues a status result straight
//     into the result register, after which busy drops.
//   unused code: S_EXEC only, no result.
//   pop: S_EXEC issues one store read; S_FLUSH registers the read data.
//   dump of N entries: after S_EXEC, S_DUMP issues one store read per cycle,
//     giving N results back to back; S_FLUSH registers the last read data.
// The single read port of the store paces dumps at one entry per cycle.
// Reset clears both stack counts and the controller; store contents are
// not cleared and need no clearing pass, since only written entries are read.
module dual_stack_shared_buffer import dssb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    valid,
	output result_t result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dssb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	dssb_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.valid (valid),
		.result(result)
	);

endmodule

FILE: rtl/dssb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dssb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/dssb_dp.sv
// Datapath: held transaction, stack counts, address generation, store and result register.
module dssb_dp import dssb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    item,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     valid,
	output result_t  result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] TOP_C   = CW'(DEPTH - 1);

	logic [2:0]        action_q;
	logic [DATA_W-1:0] value_q;
	logic [CW-1:0]     low_q;
	logic [CW-1:0]     high_q;
	logic [CW-1:0]     idx_q;
	logic              rd_pend_s1;
	logic              rd_last_s1;
	logic              valid_q;
	result_t           result_q;

	logic [CW:0]       fill;
	logic [CW-1:0]     addr_full;
	logic [CW-1:0]     dump_cnt;
	logic [DATA_W-1:0] rdata;

	// Held transaction
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			action_q <= item.action;
			value_q  <= item.push_value;
		end
	end

	// Stack counts and dump index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= '0;
			high_q     <= '0;
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			if (cmd.cnt_up) begin
				if (action_q == ACT_PUSH_LO) begin
					low_q <= low_q + CW'(1);
				end else begin
					high_q <= high_q + CW'(1);
				end
			end else if (cmd.cnt_down) begin
				if (action_q == ACT_POP_LO) begin
					low_q <= low_q - CW'(1);
				end else begin
					high_q <= high_q - CW'(1);
				end
			end
			if (cmd.ld_item) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			rd_pend_s1 <= cmd.rd_en;
			rd_last_s1 <= cmd.rd_last;
		end
	end

	// Status toward the controller
	assign fill     = {1'b0, low_q} + {1'b0, high_q};
	assign dump_cnt = (action_q == ACT_DUMP_HI) ? high_q : low_q;

	always_comb begin
		stat.action    = action_q;
		stat.full      = fill >= {1'b0, DEPTH_C};
		stat.lo_empty  = low_q == '0;
		stat.hi_empty  = high_q == '0;
		stat.dump_last = (idx_q + CW'(1)) == dump_cnt;
	end

	// Store address: counts are taken before their update
	always_comb begin
		unique case (action_q)
			ACT_PUSH_LO: addr_full = low_q;
			ACT_PUSH_HI: addr_full = TOP_C - high_q;
			ACT_POP_LO:  addr_full = low_q - CW'(1);
			ACT_POP_HI:  addr_full = DEPTH_C - high_q;
			ACT_DUMP_LO: addr_full = idx_q;
			ACT_DUMP_HI: addr_full = TOP_C - idx_q;
			default:     addr_full = '0;
		endcase
	end

	dssb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(addr_full[AW-1:0]),
		.wdata(value_q),
		.re   (cmd.rd_en),
		.raddr(addr_full[AW-1:0]),
		.rdata(rdata)
	);

	// Result register: registered store read data when a read is pending, else a status-only result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= rd_pend_s1 | cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			result_q.data_out <= rdata;
			result_q.status   <= ST_OK;
			result_q.last     <= rd_last_s1;
		end else if (cmd.emit) begin
			result_q.data_out <= (cmd.emit_st == ST_UNDER) ? '1 : '0;
			result_q.status   <= cmd.emit_st;
			result_q.last     <= 1'b1;
		end
	end

	assign valid  = valid_q;
	assign result = result_q;

endmodule

FILE: rtl/dssb_ctrl.sv
// Controller: sequences one transaction at a time over the datapath.
module dssb_ctrl import dssb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.ld_item = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (stat.action)
					ACT_PUSH_LO, ACT_PUSH_HI: begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.emit_st = ST_OVER;
						end else begin
							cmd.emit_st = ST_OK;
							cmd.wr_en   = 1'b1;
							cmd.cnt_up  = 1'b1;
						end
					end
					ACT_POP_LO, ACT_POP_HI: begin
						if ((stat.action == ACT_POP_LO) ? stat.lo_empty : stat.hi_empty) begin
							cmd.emit    = 1'b1;
							cmd.emit_st = ST_UNDER;
						end else begin
							cmd.rd_en    = 1'b1;
							cmd.rd_last  = 1'b1;
							cmd.cnt_down = 1'b1;
							state_d      = S_FLUSH;
						end
					end
					ACT_DUMP_LO, ACT_DUMP_HI: begin
						if ((stat.action == ACT_DUMP_LO) ? stat.lo_empty : stat.hi_empty) begin
							cmd.emit    = 1'b1;
							cmd.emit_st = ST_EMPTY;
						end else begin
							state_d = S_DUMP;
						end
					end
					default: begin
						// unused codes: no result, no change
					end
				endcase
			end
			S_DUMP: begin
				cmd.rd_en   = 1'b1;
				cmd.idx_inc = 1'b1;
				cmd.rd_last = stat.dump_last;
				if (stat.dump_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				// last read data lands in the result register
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: verif/dssb_checker.sv
// Checker for the dual stack shared buffer: predicts every result and compares.
`timescale 1ns / 100ps

module dssb_checker import dssb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    valid,
	input  result_t result,
	output int      fail_count,
	output int      pending,
	output int      lo_fill,
	output int      hi_fill
);

	// Predicted contents of the shared store and the two stack depths
	logic signed [DATA_W-1:0] stack_mem [DEPTH];
	int lo_cnt = 0;
	int hi_cnt = 0;

	// Results still owed by the block, oldest first
	result_t stack_results_q [$];
	int mismatches = 0;

	// Apply one accepted transaction to the predicted stacks
	task automatic apply_stack_action(input item_t it);
		result_t r;
		bit      full;
		full = (lo_cnt + hi_cnt) >= DEPTH;
		r = '0;
		r.last = 1'b1;
		case (it.action)
			ACT_PUSH_LO, ACT_PUSH_HI: begin
				if (full) begin
					r.status = ST_OVER;
				end else if (it.action == ACT_PUSH_LO) begin
					stack_mem[lo_cnt] = it.push_value;
					lo_cnt++;
					r.status = ST_OK;
				end else begin
					hi_cnt++;
					stack_mem[DEPTH - hi_cnt] = it.push_value;
					r.status = ST_OK;
				end
				stack_results_q.push_back(r);
			end
			ACT_POP_LO: begin
				if (lo_cnt == 0) begin
					r.data_out = -1;
					r.status   = ST_UNDER;
				end else begin
					lo_cnt--;
					r.data_out = stack_mem[lo_cnt];
					r.status   = ST_OK;
				end
				stack_results_q.push_back(r);
			end
			ACT_POP_HI: begin
				if (hi_cnt == 0) begin
					r.data_out = -1;
					r.status   = ST_UNDER;
				end else begin
					r.data_out = stack_mem[DEPTH - hi_cnt];
					r.status   = ST_OK;
					hi_cnt--;
				end
				stack_results_q.push_back(r);
			end
			ACT_DUMP_LO: begin
				if (lo_cnt == 0) begin
					r.status = ST_EMPTY;
					stack_results_q.push_back(r);
				end else begin
					// bottom (entry 0) up to the top of the first stack
					for (int i = 0; i < lo_cnt; i++) begin
						r.data_out = stack_mem[i];
						r.status   = ST_OK;
						r.last     = (i == lo_cnt - 1);
						stack_results_q.push_back(r);
					end
				end
			end
			ACT_DUMP_HI: begin
				if (hi_cnt == 0) begin
					r.status = ST_EMPTY;
					stack_results_q.push_back(r);
				end else begin
					// top entry of the store downward
					for (int i = 0; i < hi_cnt; i++) begin
						r.data_out = stack_mem[DEPTH - 1 - i];
						r.status   = ST_OK;
						r.last     = (i == hi_cnt - 1);
						stack_results_q.push_back(r);
					end
				end
			end
			default: ; // unused codes: no result, no state change
		endcase
	endtask

	// Count a failure; only the first few are printed
	task automatic report_mismatch(input string why, input result_t exp_r, input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected %0d st %0d last %0b, got %0d st %0d last %0b",
				$realtime, why, exp_r.data_out, exp_r.status, exp_r.last,
				got.data_out, got.status, got.last);
		end
	endtask

	// Sample both channels on the rising edge, results before new work
	always @(posedge clk) begin : watch
		result_t exp_r;
		if (arst_n) begin
			if (valid) begin
				if (stack_results_q.size() == 0) begin
					report_mismatch("unexpected result", '0, result);
				end else begin
					exp_r = stack_results_q.pop_front();
					if (result.data_out !== exp_r.data_out || result.status !== exp_r.status ||
						result.last !== exp_r.last) begin
						report_mismatch("result mismatch", exp_r, result);
					end
				end
			end
			if (start && !busy) begin
				apply_stack_action(item);
			end
		end
		fail_count <= mismatches;
		pending    <= stack_results_q.size();
		lo_fill    <= lo_cnt;
		hi_fill    <= hi_cnt;
	end

endmodule

FILE: verif/testbench.sv
// Top of the dual stack shared buffer testbench: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module testbench;
	import dssb_pkg::*;

	localparam int DEPTH        = 64;
	localparam int RANDOM_ITEMS = 330;
	localparam int CYCLE_LIMIT  = 300000;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    valid;
	result_t result;

	int fail_count;
	int pending;
	int lo_fill;
	int hi_fill;
	int idle_pct    = 0;
	int actions_cnt = 0;
	int cycles      = 0;

	dual_stack_shared_buffer #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.valid  (valid),
		.result (result)
	);

	dssb_checker #(.DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.valid      (valid),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending),
		.lo_fill    (lo_fill),
		.hi_fill    (hi_fill)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** dual_stack_shared_buffer: FAILED **");
			$finish;
		end
	end

	// Offer one transaction, with random idle cycles first; returns at the accepting edge
	task automatic send_action(input logic [2:0] act, input logic signed [DATA_W-1:0] val);
		item_t it;
		it.action     = act;
		it.push_value = val;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		actions_cnt++;
	endtask

	// Stop offering work until every owed result has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Push data, biased toward the extremes
	function automatic logic signed [DATA_W-1:0] push_data();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int side;
		int n;
		int ep;
		logic [2:0] act;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty stacks, extremes, every action, unused codes
		send_action(ACT_POP_LO, 0);
		send_action(ACT_POP_HI, 0);
		send_action(ACT_DUMP_LO, 0);
		send_action(ACT_DUMP_HI, 0);
		send_action(3'd6, 32'h5555_5555);
		send_action(3'd7, 32'hAAAA_AAAA);
		send_action(ACT_PUSH_LO, 32'h7FFF_FFFF);
		send_action(ACT_PUSH_LO, 32'h8000_0000);
		send_action(ACT_PUSH_LO, 32'h0000_0000);
		send_action(ACT_PUSH_HI, 32'hFFFF_FFFF);
		send_action(ACT_PUSH_HI, 32'h8000_0000);
		send_action(ACT_PUSH_HI, 32'h7FFF_FFFF);
		send_action(ACT_DUMP_LO, 0);
		send_action(ACT_DUMP_HI, 0);
		send_action(ACT_POP_HI, 0);
		send_action(ACT_POP_LO, 0);
		send_action(ACT_DUMP_HI, 0);
		send_action(ACT_DUMP_LO, 0);
		repeat (3) send_action(ACT_POP_LO, 0);
		repeat (3) send_action(ACT_POP_HI, 0);
		drain_results();

		// Random episodes: mostly fills, drains and push/pop mixes
		actions_cnt = 0;
		ep = 0;
		while (actions_cnt < RANDOM_ITEMS) begin
			case (ep % 4)
				0: idle_pct = 0;
				1: idle_pct = 76;
				2: idle_pct = 8;
				default: idle_pct = $urandom_range(1) ? 76 : 0;
			endcase
			ep++;
			case ($urandom_range(9))
				0, 1, 2: begin
					// fill the store, overflow it, then dump both stacks
					side = $urandom_range(2);
					n = DEPTH - lo_fill - hi_fill + 2;
					repeat (n) begin
						if (side == 2)
							act = $urandom_range(1) ? ACT_PUSH_HI : ACT_PUSH_LO;
						else
							act = side ? ACT_PUSH_HI : ACT_PUSH_LO;
						send_action(act, push_data());
					end
					send_action(ACT_DUMP_LO, $urandom());
					send_action(ACT_DUMP_HI, $urandom());
				end
				3, 4, 5: begin
					// pop both stacks past empty
					n = lo_fill + 2;
					repeat (n) send_action(ACT_POP_LO, $urandom());
					n = hi_fill + 2;
					repeat (n) send_action(ACT_POP_HI, $urandom());
					send_action($urandom_range(1) ? ACT_DUMP_LO : ACT_DUMP_HI, $urandom());
				end
				6, 7: begin
					// push-heavy mix of all actions
					repeat (20) begin
						if ($urandom_range(1))
							act = 3'($urandom_range(1));
						else
							act = 3'($urandom_range(5, 2));
						send_action(act, push_data());
					end
				end
				8: begin
					// noise, unused codes included
					repeat (12) send_action(3'($urandom_range(7)), $urandom());
				end
				default: begin
					// quiet block, then dump both stacks
					drain_results();
					send_action(ACT_DUMP_LO, $urandom());
					send_action(ACT_DUMP_HI, $urandom());
				end
			endcase
		end

		// Let everything owed come back, then a few more cycles
		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** dual_stack_shared_buffer: PASSED **");
		else
			$display("** dual_stack_shared_buffer: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
rtl/dssb_pkg.sv
rtl/dssb_ram.sv
rtl/dssb_dp.sv
rtl/dssb_ctrl.sv
rtl/dual_stack_shared_buffer.sv
verif/dssb_checker.sv
verif/testbench.sv
